/* src/assert_macros.svh */
// Assertion macros shared by the matrix inverse RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define MI3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the next cycle, outside reset.
`define MI3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Implication whose consequent is checked in the next cycle, also during reset.
`define MI3_ASSERT_NEXT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* src/mi3_pkg.sv */
// Shared widths, types and cofactor index tables for the 3x3 matrix inverse.
// No dependencies; imported by every module of the block.
`default_nettype none

package mi3_pkg;

  // Number format of the elements.
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NEL        = 9;

  // Derived widths: products, cofactors, determinant, remainder, compare.
  localparam int DW   = DATA_WIDTH;
  localparam int PW   = 2 * DW;
  localparam int AW   = PW + 1;
  localparam int HW   = AW - DW;
  localparam int DETW = DW + AW + 2;
  localparam int RW   = AW + 2 * FRAC_BITS;
  localparam int QB   = DW;
  localparam int SW   = DETW + QB;
  localparam int CW   = ((RW > SW) ? RW : SW) + 1;

  typedef logic signed [DW-1:0]   elem_t;
  typedef logic signed [PW-1:0]   prod_t;
  typedef logic signed [AW-1:0]   adj_t;
  typedef logic signed [PW:0]     dprod_t;
  typedef logic signed [DETW-1:0] det_t;
  typedef logic [AW-1:0]          nmag_t;
  typedef logic [DETW-1:0]        dmag_t;
  typedef logic [RW-1:0]          rem_t;
  typedef logic [QB-1:0]          quot_t;
  typedef logic [CW-1:0]          cmp_t;

  // Per-lane flags that travel with a quotient through the divider.
  typedef struct packed {
    logic big;
    logic rneg;
  } lane_t;

  // Cofactor k of the adjugate is m[A]*m[B] - m[C]*m[D] (row-major index).
  localparam int COF_A [NEL] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int COF_B [NEL] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int COF_C [NEL] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int COF_D [NEL] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  // First-row expansion of the determinant: m[0][i] times adjugate entry.
  localparam int DET_ADJ [3] = '{0, 3, 6};

endpackage

`default_nettype wire

/* src/mi3_adj.sv */
// Adjugate stages: cofactor products, then their differences.
// Depends on mi3_pkg.
`default_nettype none

module mi3_adj
  import mi3_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  vld_i,
  input  elem_t      m_i   [NEL],
  output logic       vld_o,
  output elem_t      row_o [3],
  output adj_t       adj_o [NEL]
);

  logic  vp_r, va_r;
  prod_t pa_r [NEL];
  prod_t pb_r [NEL];
  elem_t rp_r [3];
  elem_t ra_r [3];
  adj_t  adj_r [NEL];

  // Valid bits of the two stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
      va_r <= 1'b0;
    end else if (en) begin
      vp_r <= vld_i;
      va_r <= vp_r;
    end
  end

  // Stage one forms both products of each cofactor; stage two subtracts.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NEL; k++) begin
        pa_r[k]  <= m_i[COF_A[k]] * m_i[COF_B[k]];
        pb_r[k]  <= m_i[COF_C[k]] * m_i[COF_D[k]];
        adj_r[k] <= adj_t'(pa_r[k]) - adj_t'(pb_r[k]);
      end
      for (int i = 0; i < 3; i++) begin
        rp_r[i] <= m_i[i];
        ra_r[i] <= rp_r[i];
      end
    end
  end

  assign vld_o = va_r;
  assign row_o = ra_r;
  assign adj_o = adj_r;

endmodule

`default_nettype wire

/* src/mi3_det.sv */
// Determinant stages: split partial products of the first row, then their sum.
// Depends on mi3_pkg.
`default_nettype none

module mi3_det
  import mi3_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  vld_i,
  input  elem_t      row_i [3],
  input  adj_t       adj_i [NEL],
  output logic       vld_o,
  output det_t       det_o,
  output adj_t       adj_o [NEL]
);

  logic   vp_r, vs_r;
  dprod_t lo_r [3];
  dprod_t hi_r [3];
  adj_t   ap_r [NEL];
  adj_t   as_r [NEL];
  det_t   det_r;
  det_t   det_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
      vs_r <= 1'b0;
    end else if (en) begin
      vp_r <= vld_i;
      vs_r <= vp_r;
    end
  end

  // Each adjugate entry is cut into an unsigned low word and a signed high part.
  always_comb begin
    det_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      det_nxt = det_nxt + (det_t'(hi_r[i]) <<< DW) + det_t'(lo_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        lo_r[i] <= row_i[i] * $signed({1'b0, adj_i[DET_ADJ[i]][DW-1:0]});
        hi_r[i] <= row_i[i] * $signed(adj_i[DET_ADJ[i]][AW-1:DW]);
      end
      ap_r  <= adj_i;
      as_r  <= ap_r;
      det_r <= det_nxt;
    end
  end

  assign vld_o = vs_r;
  assign det_o = det_r;
  assign adj_o = as_r;

endmodule

`default_nettype wire

/* src/mi3_div.sv */
// Sign handling and restoring divider pipeline, one quotient bit per stage.
// Depends on mi3_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mi3_div
  import mi3_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  vld_i,
  input  det_t       det_i,
  input  adj_t       adj_i  [NEL],
  output logic       vld_o,
  output logic       sing_o,
  output quot_t      q_o    [NEL],
  output lane_t      lf_o   [NEL]
);

  // First prep stage: magnitudes and signs.
  logic  v1_r, z1_r;
  dmag_t dm1_r;
  nmag_t nm1_r [NEL];
  logic  rn1_r [NEL];

  // Divider stages; index 0 is loaded by the second prep stage.
  logic  vld_r  [QB+1];
  logic  sing_r [QB+1];
  dmag_t dm_r   [QB+1];
  rem_t  rem_r  [QB+1][NEL];
  quot_t q_r    [QB+1][NEL];
  lane_t lf_r   [QB+1][NEL];

  rem_t  rem_nxt [QB][NEL];
  quot_t q_nxt   [QB][NEL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      for (int s = 0; s <= QB; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (en) begin
      v1_r     <= vld_i;
      vld_r[0] <= v1_r;
      for (int s = 0; s < QB; s++) begin
        vld_r[s+1] <= vld_r[s];
      end
    end
  end

  // Prep: absolute values, result sign, zero determinant, then the range check.
  always_ff @(posedge clk) begin
    if (en) begin
      z1_r  <= (det_i == '0);
      dm1_r <= det_i[DETW-1] ? dmag_t'(-det_i) : dmag_t'(det_i);
      for (int l = 0; l < NEL; l++) begin
        nm1_r[l] <= adj_i[l][AW-1] ? nmag_t'(-adj_i[l]) : nmag_t'(adj_i[l]);
        rn1_r[l] <= adj_i[l][AW-1] ^ det_i[DETW-1];
      end
      sing_r[0] <= z1_r;
      dm_r[0]   <= dm1_r;
      for (int l = 0; l < NEL; l++) begin
        rem_r[0][l]     <= {nm1_r[l], {(2*FRAC_BITS){1'b0}}};
        q_r[0][l]       <= '0;
        lf_r[0][l].rneg <= rn1_r[l];
        lf_r[0][l].big  <= (cmp_t'({nm1_r[l], {(2*FRAC_BITS){1'b0}}})
                            >= cmp_t'({dm1_r, {QB{1'b0}}}));
      end
    end
  end

  // Each stage tries the divisor shifted to the next lower quotient bit.
  always_comb begin
    for (int s = 0; s < QB; s++) begin
      for (int l = 0; l < NEL; l++) begin
        if (cmp_t'(rem_r[s][l]) >= (cmp_t'(dm_r[s]) << (QB - 1 - s))) begin
          rem_nxt[s][l] = RW'(cmp_t'(rem_r[s][l]) - (cmp_t'(dm_r[s]) << (QB - 1 - s)));
          q_nxt[s][l]   = {q_r[s][l][QB-2:0], 1'b1};
        end else begin
          rem_nxt[s][l] = rem_r[s][l];
          q_nxt[s][l]   = {q_r[s][l][QB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < QB; s++) begin
        sing_r[s+1] <= sing_r[s];
        dm_r[s+1]   <= dm_r[s];
        for (int l = 0; l < NEL; l++) begin
          rem_r[s+1][l] <= rem_nxt[s][l];
          q_r[s+1][l]   <= q_nxt[s][l];
          lf_r[s+1][l]  <= lf_r[s][l];
        end
      end
    end
  end

  assign vld_o  = vld_r[QB];
  assign sing_o = sing_r[QB];
  assign q_o    = q_r[QB];
  assign lf_o   = lf_r[QB];

  // An in-range quotient must leave a remainder below the divisor.
  for (genvar g = 0; g < NEL; g++) begin : g_chk
    `MI3_ASSERT(a_rem_below_div, !(vld_r[QB] && !sing_r[QB] && !lf_r[QB][g].big) || (cmp_t'(rem_r[QB][g]) < cmp_t'(dm_r[QB])), "divider remainder not below divisor")
  end

endmodule

`default_nettype wire

/* src/matrix_inverse_3x3_core.sv */
// Top level of the 3x3 fixed-point matrix inverse.
// Depends on mi3_pkg, mi3_adj, mi3_det, mi3_div and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// One 3x3 matrix of signed Q16.16 elements enters per word and its inverse,
// computed as the adjugate divided by the determinant with exact integer
// arithmetic and a truncating quotient, leaves as one word. A new matrix is
// taken every cycle while the output is not stalled. Most of the pipeline is
// the 32-stage restoring divider that resolves one quotient bit per stage for
// all nine elements in parallel (two adjugate, two determinant, two sign/range
// and one output stage make up the rest). The whole pipeline holds while the
// output word is stalled. A zero determinant gives all-zero elements with
// singular set; elements beyond the Q16.16 range saturate and set overflow.
module matrix_inverse_3x3_core
  import mi3_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // in_r0c0, in_r0c1, in_r0c2, in_r1c0, ... in_r2c2, 32 bits each
  input  wire logic [NEL*DW-1:0] in_tdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // out_r0c0, out_r0c1, out_r0c2, out_r1c0, ... out_r2c2, 32 bits each
  output logic [NEL*DW-1:0]      out_tdata,
  // singular, overflow
  output logic [1:0]             out_tuser
);

  localparam quot_t HALF = quot_t'(1) << (DW - 1);

  logic  en;
  elem_t m_in [NEL];
  logic  a_vld, d_vld, q_vld, q_sing;
  elem_t a_row [3];
  adj_t  a_adj [NEL];
  det_t  d_det;
  adj_t  d_adj [NEL];
  quot_t q_val [NEL];
  lane_t q_lf  [NEL];

  logic              out_valid_r;
  logic [NEL*DW-1:0] out_data_r, out_data_nxt;
  logic [1:0]        out_user_r, out_user_nxt;

  // The pipeline moves whenever the output register is free or being drained.
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_comb begin
    for (int k = 0; k < NEL; k++) begin
      m_in[k] = $signed(in_tdata[k*DW +: DW]);
    end
  end

  mi3_adj u_adj (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (in_tvalid),
    .m_i   (m_in),
    .vld_o (a_vld),
    .row_o (a_row),
    .adj_o (a_adj)
  );

  mi3_det u_det (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (a_vld),
    .row_i (a_row),
    .adj_i (a_adj),
    .vld_o (d_vld),
    .det_o (d_det),
    .adj_o (d_adj)
  );

  mi3_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (d_vld),
    .det_i  (d_det),
    .adj_i  (d_adj),
    .vld_o  (q_vld),
    .sing_o (q_sing),
    .q_o    (q_val),
    .lf_o   (q_lf)
  );

  // Zero every element if singular; else saturate each quotient and apply its sign.
  always_comb begin
    logic  ovf;
    quot_t mag;
    ovf = 1'b0;
    for (int l = 0; l < NEL; l++) begin
      mag = q_val[l];
      if (q_sing) begin
        out_data_nxt[l*DW +: DW] = '0;
      end else if (q_lf[l].rneg) begin
        if (q_lf[l].big || (q_val[l] > HALF)) begin
          ovf = 1'b1;
          mag = HALF;
        end
        out_data_nxt[l*DW +: DW] = DW'(-mag);
      end else begin
        if (q_lf[l].big || (q_val[l] > HALF - quot_t'(1))) begin
          ovf = 1'b1;
          mag = HALF - quot_t'(1);
        end
        out_data_nxt[l*DW +: DW] = DW'(mag);
      end
    end
    out_user_nxt = {ovf & !q_sing, q_sing};
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `MI3_ASSERT(a_flag_excl, !(out_valid_r && out_user_r[0] && out_user_r[1]), "singular and overflow both set")
  `MI3_ASSERT(a_sing_zero, !(out_valid_r && out_user_r[0]) || (out_data_r == '0), "singular word with nonzero data")
  `MI3_ASSERT_NEXT_RST(a_rst_empty, !rst_n, !out_valid_r, "output valid after reset")

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking bench for the 3x3 fixed-point matrix inverse core.
// Needs mi3_pkg and matrix_inverse_3x3_core; predicts each inverse exactly and
// compares it element by element under random idling on both sides.
`timescale 1ns / 1ps

module tb_top
  import mi3_pkg::*;
();

  localparam int LATENCY = 39;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1080;

  // One inverse word: nine elements plus the two flags.
  typedef struct {
    logic [31:0] el [9];
    logic        singular;
    logic        overflow;
  } inverse_t;

  // Directed row: a matrix and, where it is obvious, the inverse it gives.
  typedef struct {
    logic [31:0] m [9];
    logic        known;
    logic [31:0] inv [9];
    logic        singular;
    logic        overflow;
  } matrix_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [NEL*DW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [NEL*DW-1:0] out_tdata;
  logic [1:0] out_tuser;

  inverse_t pending_inverses[$];
  matrix_row_t directed_rows[$];
  int mismatches = 0;
  int matrices_sent = 0;
  int inverses_seen = 0;
  int singular_seen = 0;
  int overflow_seen = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_receiver = 1'b0;
  bit stimulus_done = 1'b0;

  always #5 clk = ~clk;

  matrix_inverse_3x3_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // Exact inverse: adjugate times 2^32 divided by the determinant, truncated.
  function automatic inverse_t predict_inverse(logic [31:0] m [9]);
    inverse_t res;
    logic signed [191:0] e [9];
    logic signed [191:0] adj [9];
    logic signed [191:0] det, num, quo;
    logic signed [191:0] max_v, min_v;
    int ia [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    int ib [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    int ic [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    int id [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
    max_v = 192'sd2147483647;
    min_v = -192'sd2147483648;
    for (int k = 0; k < 9; k++) e[k] = {{160{m[k][31]}}, m[k]};
    for (int k = 0; k < 9; k++) adj[k] = e[ia[k]] * e[ib[k]] - e[ic[k]] * e[id[k]];
    det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
    res.singular = (det == 0);
    res.overflow = 1'b0;
    for (int k = 0; k < 9; k++) begin
      if (res.singular) begin
        res.el[k] = '0;
      end else begin
        num = adj[k] <<< 32;
        quo = num / det;
        if (quo > max_v) begin
          quo = max_v;
          res.overflow = 1'b1;
        end else if (quo < min_v) begin
          quo = min_v;
          res.overflow = 1'b1;
        end
        res.el[k] = quo[31:0];
      end
    end
    return res;
  endfunction

  function automatic logic [31:0] rand_element();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return 32'($signed($urandom_range(0, 512)) - 256);
      3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 64 << 16)) - (32 << 16));
    endcase
  endfunction

  // Some well-conditioned matrices; some singular by a repeated row, a repeated
  // column or a zero row; the rest random noise.
  task automatic random_matrix(output logic [31:0] m [9]);
    int kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) m[k] = rand_element();
    if (kind < 4) begin
      // Diagonally dominant, so the inverse usually stays in range.
      for (int k = 0; k < 9; k++)
        m[k] = 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
      m[0] = 32'(($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(4 << 16, 20 << 16)));
      m[4] = 32'(($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(4 << 16, 20 << 16)));
      m[8] = 32'(($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(4 << 16, 20 << 16)));
    end else if (kind == 4) begin
      for (int c = 0; c < 3; c++) m[3 + c] = m[c];
    end else if (kind == 5) begin
      for (int c = 0; c < 3; c++) m[3 * $urandom_range(0, 2) + c] = '0;
    end else if (kind == 6) begin
      for (int r = 0; r < 3; r++) m[3 * r + 2] = m[3 * r];
    end
  endtask

  // Offer one word, idling first when the sender is asked to; valid stays
  // high between back-to-back words.
  task automatic send_matrix(logic [31:0] m [9]);
    logic [NEL*DW-1:0] word;
    for (int k = 0; k < 9; k++) word[32 * k +: 32] = m[k];
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    matrices_sent++;
    pending_inverses.push_back(predict_inverse(m));
  endtask

  task automatic add_row(logic [31:0] a0, logic [31:0] a1, logic [31:0] a2,
                         logic [31:0] a3, logic [31:0] a4, logic [31:0] a5,
                         logic [31:0] a6, logic [31:0] a7, logic [31:0] a8,
                         logic known, logic [31:0] diag, logic sing, logic ovf);
    matrix_row_t row;
    row.m = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
    row.known = known;
    row.inv = '{diag, 0, 0, 0, diag, 0, 0, 0, diag};
    row.singular = sing;
    row.overflow = ovf;
    directed_rows.push_back(row);
  endtask

  // Receiver: random stalls, or a long hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !hold_receiver && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare each inverse word with the oldest prediction.
  always @(posedge clk) begin
    inverse_t want;
    logic bad;
    if (rst_n && out_tvalid && out_tready) begin
      inverses_seen++;
      if (out_tuser[0]) singular_seen++;
      if (out_tuser[1]) overflow_seen++;
      if (pending_inverses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected inverse word %h", out_tdata);
      end else begin
        want = pending_inverses.pop_front();
        bad = (out_tuser[0] !== want.singular) || (out_tuser[1] !== want.overflow);
        for (int k = 0; k < 9; k++) if (out_tdata[32 * k +: 32] !== want.el[k]) bad = 1'b1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Inverse mismatch at word %0d:", inverses_seen);
            for (int k = 0; k < 9; k++)
              $display("  element %0d expected %h actual %h", k, want.el[k],
                       out_tdata[32 * k +: 32]);
            $display("  singular expected %b actual %b, overflow expected %b actual %b",
                     want.singular, out_tuser[0], want.overflow, out_tuser[1]);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (rst_n && !(stimulus_done && pending_inverses.size() == 0)) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout with %0d inverses outstanding", pending_inverses.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] m [9];
    matrix_row_t row;
    int n_rand;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity, scaled identities, singular and saturating cases.
    add_row(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 1, 32'h10000, 0, 0);
    add_row(32'h20000, 0, 0, 0, 32'h20000, 0, 0, 0, 32'h20000, 1, 32'h8000, 0, 0);
    add_row(32'hFFFF0000, 0, 0, 0, 32'hFFFF0000, 0, 0, 0, 32'hFFFF0000,
            1, 32'hFFFF0000, 0, 0);
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0);
    add_row(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
            32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 0, 1, 0);
    add_row(1, 0, 0, 0, 1, 0, 0, 0, 1, 1, 32'h7FFFFFFF, 0, 1);
    add_row(32'hFFFFFFFF, 0, 0, 0, 32'hFFFFFFFF, 0, 0, 0, 32'hFFFFFFFF,
            1, 32'h80000000, 0, 1);
    add_row(32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 0);
    add_row(32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 0);
    add_row(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
            32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0);
    add_row(32'h7FFFFFFF, 32'h80000000, 32'h55555555, 32'hAAAAAAAA, 32'h7FFFFFFF,
            32'h80000000, 32'h12345678, 32'hEDCBA987, 32'h7FFFFFFF, 0, 0, 0, 0);
    add_row(0, 32'h10000, 0, 0, 0, 32'h10000, 32'h10000, 0, 0, 0, 0, 0, 0);
    add_row(32'h10000, 32'h20000, 32'h30000, 32'h40000, 32'h50000, 32'h60000,
            32'h70000, 32'h80000, 32'h90000, 1, 0, 1, 0);
    add_row(32'h20000, 32'h10000, 0, 32'h10000, 32'h20000, 32'h10000, 0, 32'h10000,
            32'h20000, 0, 0, 0, 0);
    add_row(32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h00000001, 32'hFFFF0000,
            32'h0000FFFF, 32'h80000001, 32'h7FFFFFFE, 32'hAAAA5555, 0, 0, 0, 0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_matrix(row.m);
      // Where the inverse is plain, replace the prediction by the typed value.
      if (row.known) begin
        pending_inverses[pending_inverses.size() - 1].el = row.inv;
        pending_inverses[pending_inverses.size() - 1].singular = row.singular;
        pending_inverses[pending_inverses.size() - 1].overflow = row.overflow;
      end
    end

    // Random phases with different idling mixes.
    n_rand = 0;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        3: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (phase == 4) begin
        // Hold the receiver for a long stretch so the pipeline backs up.
        fork
          begin
            hold_receiver = 1'b1;
            repeat (150) @(posedge clk);
            hold_receiver = 1'b0;
          end
          repeat (120) begin
            random_matrix(m);
            send_matrix(m);
          end
        join
        n_rand += 120;
      end
      repeat ((N_RANDOM - 120) / 5) begin
        random_matrix(m);
        send_matrix(m);
        n_rand++;
      end
    end
    in_tvalid <= 1'b0;

    stimulus_done = 1'b1;
    wait (pending_inverses.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d matrices (%0d random) under mixed idling; %0d inverses checked,",
             matrices_sent, n_rand, inverses_seen);
    $display("%0d singular, %0d saturated, %0d mismatches.",
             singular_seen, overflow_seen, mismatches);
    if (mismatches == 0 && pending_inverses.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
